/* sv/tiir_pkg.sv */
// tiir_pkg: shared types and constants of the transposed iir filter
// used by transposed_iir_filter; depends on nothing else
`timescale 1ns / 1ps
`default_nettype none

package tiir_pkg;

    // field widths of one item
    localparam int unsigned OPCODE_W = 2;
    localparam int unsigned IDX_W    = 5;
    localparam int unsigned COEF_W   = 32;
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned STATE_W  = 48;
    localparam int unsigned PROD_W   = COEF_W + SAMPLE_W;

    // input tdata layout, lowest bits first, padded to whole bytes
    localparam int unsigned IDX_LSB    = 0;
    localparam int unsigned CVAL_LSB   = IDX_LSB + IDX_W;
    localparam int unsigned SAMPLE_LSB = CVAL_LSB + COEF_W;
    localparam int unsigned IN_BITS    = SAMPLE_LSB + SAMPLE_W;
    localparam int unsigned IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    // coefficient store entry holds {a_k, b_k}
    localparam int unsigned CENTRY_W = 2 * COEF_W;

    // b0 = 1.0 in q7.24
    localparam logic signed [COEF_W-1:0] B0_ONE = 32'sh0100_0000;

    // output accumulator: q9.39, the q8.39 state plus one headroom bit, rounding constant 2^23
    localparam int unsigned ACC_W = STATE_W + 1;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = 49'sd8388608;
    localparam int unsigned Q_W = ACC_W - 24;
    localparam logic signed [Q_W-1:0] Y_MAX = 25'sd32767;
    localparam logic signed [Q_W-1:0] Y_MIN = -25'sd32768;

    // delay update sum before saturation to 48 bits
    localparam int unsigned SUM_W = STATE_W + 2;
    localparam logic signed [SUM_W-1:0] ST_MAX = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [SUM_W-1:0] ST_MIN = 50'sh3_8000_0000_0000;

    typedef enum logic [OPCODE_W-1:0] {
        OP_FILTER = 2'd0,
        OP_WR_NUM = 2'd1,
        OP_WR_DEN = 2'd2,
        OP_CLEAR  = 2'd3
    } t_opcode;

endpackage

`default_nettype wire

/* sv/tiir_ram.sv */
// tiir_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module tiir_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 8
) (
    input  wire                                    i_clk,
    input  wire                                    i_we,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]                       i_wdata,
    input  wire                                    i_re,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/transposed_iir_filter.sv */
// transposed_iir_filter: transposed direct form ii iir filter, top level
// depends on tiir_pkg and tiir_ram
`timescale 1ns / 1ps
`default_nettype none

// usage
//   slave channel: one item per handshake; tuser carries the opcode (filter a
//   sample, write a numerator or denominator coefficient, clear the delays),
//   tdata carries coef_index, coef_value and sample_in
//   master channel: one item per filtered sample; tdata is sample_out, tuser
//   is the overflow flag; writes and clears give no item
//   a filter item runs through the states Y0, Y1, the tap walk, a drain step and
//   the output state before the next item is accepted: the coefficient memory
//   has one read port, so the taps are walked one per cycle; the result
//   register loads in the output state, once the previous result is taken
//   a coefficient write reads the entry, merges the new value and writes it
//   back; a clear or an ignored write leaves the block idle for the next item
//   reset gives b0 = 1.0 and all other coefficients and delays zero through
//   per-entry valid bits, so the filter passes samples straight through and
//   no clearing pass is needed
//   if the receiver stalls, the finished item waits in the output register and
//   the block holds before loading the next one; nothing is dropped
module transposed_iir_filter #(
    parameter int unsigned ORDER = 8
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // slave side
    input  wire                                   i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // tdata: coef_index[4:0], coef_value[36:5], sample_in[52:37], zero pad
    input  wire  [tiir_pkg::IN_TDATA_W-1:0]       i_s_axis_tdata,
    // tuser: opcode[1:0]
    input  wire  [tiir_pkg::OPCODE_W-1:0]         i_s_axis_tuser,
    // master side
    output logic                                  o_m_axis_tvalid,
    input  wire                                   i_m_axis_tready,
    // tdata: sample_out[15:0]
    output logic [tiir_pkg::SAMPLE_W-1:0]         o_m_axis_tdata,
    // tuser: overflow[0]
    output logic [0:0]                            o_m_axis_tuser
);

    // address widths of the two memories
    localparam int unsigned CDEPTH = ORDER + 1;
    localparam int unsigned CAW    = $clog2(CDEPTH);
    localparam int unsigned DAW    = (ORDER > 1) ? $clog2(ORDER) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CW,
        S_Y0,
        S_Y1,
        S_TAP,
        S_DRAIN,
        S_OUT
    } t_state;

    t_state r_state;

    // item fields as taken from the slave side
    tiir_pkg::t_opcode                     s_op;
    logic [tiir_pkg::IDX_W-1:0]            s_idx;
    logic signed [tiir_pkg::COEF_W-1:0]    s_cval;
    logic signed [tiir_pkg::SAMPLE_W-1:0]  s_x;
    logic                                  s_acc;

    // latched item
    tiir_pkg::t_opcode                     r_op;
    logic signed [tiir_pkg::COEF_W-1:0]    r_cval;
    logic signed [tiir_pkg::SAMPLE_W-1:0]  r_x;
    logic [CAW-1:0]                        r_entry;

    // valid bits: an entry not yet written reads as its reset value
    logic [CDEPTH-1:0]                     r_cvalid;
    logic [ORDER-1:0]                      r_dvalid;
    logic                                  r_cv_ok;
    logic                                  r_c0;
    logic                                  r_dv_ok;

    // memory ports
    logic                                  c_re;
    logic [CAW-1:0]                        c_raddr;
    logic                                  c_we;
    logic [tiir_pkg::CENTRY_W-1:0]         c_wdata;
    logic [tiir_pkg::CENTRY_W-1:0]         c_rdata;
    logic                                  d_re;
    logic [DAW-1:0]                        d_raddr;
    logic                                  d_we;
    logic [tiir_pkg::STATE_W-1:0]          d_rdata;
    logic                                  n_dv_ok;

    // read data after reset-value substitution
    logic [tiir_pkg::CENTRY_W-1:0]         c_eff;
    logic signed [tiir_pkg::COEF_W-1:0]    c_b;
    logic signed [tiir_pkg::COEF_W-1:0]    c_a;
    logic signed [tiir_pkg::STATE_W-1:0]   d_eff;

    // datapath
    logic [CAW-1:0]                        r_k;
    logic signed [tiir_pkg::PROD_W-1:0]    r_pb;
    logic signed [tiir_pkg::PROD_W-1:0]    r_pa;
    logic signed [tiir_pkg::STATE_W-1:0]   r_sn;
    logic [DAW-1:0]                        r_widx;
    logic                                  r_mv;
    logic signed [tiir_pkg::SAMPLE_W-1:0]  r_yq;
    logic                                  r_ovf;

    logic signed [tiir_pkg::PROD_W-1:0]    n_pb;
    logic signed [tiir_pkg::PROD_W-1:0]    n_pa;
    logic signed [tiir_pkg::ACC_W-1:0]     n_acc;
    logic signed [tiir_pkg::Q_W-1:0]       n_q;
    logic signed [tiir_pkg::SAMPLE_W-1:0]  n_yq;
    logic                                  n_ysat;
    logic signed [tiir_pkg::SUM_W-1:0]     n_sum;
    logic signed [tiir_pkg::STATE_W-1:0]   n_dnew;
    logic                                  n_dsat;
    logic                                  num_ok;
    logic                                  den_ok;

    logic                                  r_m_valid;
    logic signed [tiir_pkg::SAMPLE_W-1:0]  r_m_data;
    logic                                  r_m_ovf;

    // slave side fields
    assign s_op   = tiir_pkg::t_opcode'(i_s_axis_tuser);
    assign s_idx  = i_s_axis_tdata[tiir_pkg::IDX_LSB +: tiir_pkg::IDX_W];
    assign s_cval = $signed(i_s_axis_tdata[tiir_pkg::CVAL_LSB +: tiir_pkg::COEF_W]);
    assign s_x    = $signed(i_s_axis_tdata[tiir_pkg::SAMPLE_LSB +: tiir_pkg::SAMPLE_W]);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    // out-of-range coefficient writes, and denominator writes to index 0, are dropped
    assign num_ok = (s_idx <= tiir_pkg::IDX_W'(ORDER));
    assign den_ok = (s_idx != '0) && (s_idx <= tiir_pkg::IDX_W'(ORDER));

    // coefficient and delay memories
    tiir_ram #(
        .WIDTH (tiir_pkg::CENTRY_W),
        .DEPTH (CDEPTH)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (r_entry),
        .i_wdata (c_wdata),
        .i_re    (c_re),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    tiir_ram #(
        .WIDTH (tiir_pkg::STATE_W),
        .DEPTH (ORDER)
    ) u_dly_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (r_widx),
        .i_wdata (n_dnew),
        .i_re    (d_re),
        .i_raddr (d_raddr),
        .o_rdata (d_rdata)
    );

    // read issue: entry 0 for the output term, then taps 1..ORDER one a cycle;
    // the delay one above the top tap counts as zero and is not read
    always_comb begin
        c_re    = 1'b0;
        c_raddr = '0;
        d_re    = 1'b0;
        d_raddr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    unique case (s_op)
                        tiir_pkg::OP_FILTER: begin
                            c_re = 1'b1;
                            d_re = 1'b1;
                        end
                        tiir_pkg::OP_WR_NUM: begin
                            c_re    = num_ok;
                            c_raddr = s_idx[CAW-1:0];
                        end
                        tiir_pkg::OP_WR_DEN: begin
                            c_re    = den_ok;
                            c_raddr = s_idx[CAW-1:0];
                        end
                        tiir_pkg::OP_CLEAR: begin
                            c_re = 1'b0;
                        end
                        default: begin
                            c_re = 1'b0;
                        end
                    endcase
                end
            end
            S_Y1: begin
                c_re    = 1'b1;
                c_raddr = CAW'(1);
                d_re    = (ORDER > 1);
                d_raddr = DAW'(1);
            end
            S_TAP: begin
                if ({1'b0, r_k} < (CAW + 1)'(ORDER)) begin
                    c_re    = 1'b1;
                    c_raddr = r_k + CAW'(1);
                    d_re    = ({1'b0, r_k} + (CAW + 1)'(1)) < (CAW + 1)'(ORDER);
                    d_raddr = DAW'({1'b0, r_k} + (CAW + 1)'(1));
                end
            end
            default: begin
                c_re = 1'b0;
            end
        endcase
        n_dv_ok = d_re && r_dvalid[d_raddr];
    end

    // substitute reset values for entries never written
    always_comb begin
        if (r_cv_ok) begin
            c_eff = c_rdata;
        end else if (r_c0) begin
            c_eff = {{tiir_pkg::COEF_W{1'b0}}, tiir_pkg::B0_ONE};
        end else begin
            c_eff = '0;
        end
        c_b   = $signed(c_eff[tiir_pkg::COEF_W-1:0]);
        c_a   = $signed(c_eff[tiir_pkg::CENTRY_W-1:tiir_pkg::COEF_W]);
        d_eff = r_dv_ok ? $signed(d_rdata) : '0;
    end

    // coefficient merge for the write-back
    assign c_we    = (r_state == S_CW);
    assign c_wdata = (r_op == tiir_pkg::OP_WR_NUM) ?
                     {c_a, r_cval} : {r_cval, c_b};

    // multiplier stage
    assign n_pb = tiir_pkg::PROD_W'(c_b) * tiir_pkg::PROD_W'(r_x);
    assign n_pa = tiir_pkg::PROD_W'(c_a) * tiir_pkg::PROD_W'(r_yq);

    // output: b0*x + s0, round half up to q0.15, saturate
    always_comb begin
        n_acc  = tiir_pkg::ACC_W'(r_pb) + tiir_pkg::ACC_W'(r_sn) + tiir_pkg::ROUND_HALF;
        n_q    = $signed(n_acc[tiir_pkg::ACC_W-1:24]);
        n_ysat = 1'b0;
        if (n_q > tiir_pkg::Y_MAX) begin
            n_yq   = tiir_pkg::SAMPLE_W'(tiir_pkg::Y_MAX);
            n_ysat = 1'b1;
        end else if (n_q < tiir_pkg::Y_MIN) begin
            n_yq   = tiir_pkg::SAMPLE_W'(tiir_pkg::Y_MIN);
            n_ysat = 1'b1;
        end else begin
            n_yq = n_q[tiir_pkg::SAMPLE_W-1:0];
        end
    end

    // delay update: s[i] = s[i+1] + b[i+1]*x - a[i+1]*yq, saturated to 48 bits
    always_comb begin
        n_sum  = tiir_pkg::SUM_W'(r_sn) + tiir_pkg::SUM_W'(r_pb) - tiir_pkg::SUM_W'(r_pa);
        n_dsat = 1'b0;
        if (n_sum > tiir_pkg::ST_MAX) begin
            n_dnew = tiir_pkg::STATE_W'(tiir_pkg::ST_MAX);
            n_dsat = 1'b1;
        end else if (n_sum < tiir_pkg::ST_MIN) begin
            n_dnew = tiir_pkg::STATE_W'(tiir_pkg::ST_MIN);
            n_dsat = 1'b1;
        end else begin
            n_dnew = n_sum[tiir_pkg::STATE_W-1:0];
        end
    end

    assign d_we = r_mv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cvalid  <= '0;
            r_dvalid  <= '0;
            r_cv_ok   <= 1'b0;
            r_c0      <= 1'b0;
            r_dv_ok   <= 1'b0;
            r_mv      <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            // the output state sets or holds the result flag itself
            if (i_m_axis_tready && r_state != S_OUT) begin
                r_m_valid <= 1'b0;
            end
            if (c_re) begin
                r_cv_ok <= r_cvalid[c_raddr];
                r_c0    <= (c_raddr == '0);
                r_dv_ok <= n_dv_ok;
            end
            if (c_we) begin
                r_cvalid[r_entry] <= 1'b1;
            end
            // accumulate stage, one tap behind the multipliers
            r_mv <= (r_state == S_TAP);
            if (r_mv) begin
                r_dvalid[r_widx] <= 1'b1;
                r_ovf            <= r_ovf | n_dsat;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_op    <= s_op;
                        r_cval  <= s_cval;
                        r_x     <= s_x;
                        r_entry <= s_idx[CAW-1:0];
                        unique case (s_op)
                            tiir_pkg::OP_FILTER: begin
                                r_state <= S_Y0;
                            end
                            tiir_pkg::OP_WR_NUM: begin
                                if (num_ok) begin
                                    r_state <= S_CW;
                                end
                            end
                            tiir_pkg::OP_WR_DEN: begin
                                if (den_ok) begin
                                    r_state <= S_CW;
                                end
                            end
                            tiir_pkg::OP_CLEAR: begin
                                r_dvalid <= '0;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_CW: begin
                    r_state <= S_IDLE;
                end
                S_Y0: begin
                    r_pb    <= n_pb;
                    r_sn    <= d_eff;
                    r_state <= S_Y1;
                end
                S_Y1: begin
                    r_yq    <= n_yq;
                    r_ovf   <= n_ysat;
                    r_k     <= CAW'(1);
                    r_state <= S_TAP;
                end
                S_TAP: begin
                    r_pb   <= n_pb;
                    r_pa   <= n_pa;
                    r_sn   <= d_eff;
                    r_widx <= DAW'(r_k - CAW'(1));
                    r_k    <= r_k + CAW'(1);
                    if ({1'b0, r_k} == (CAW + 1)'(ORDER)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // wait here while the previous result is still unclaimed
                    if (!r_m_valid || i_m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= r_yq;
                        r_m_ovf   <= r_ovf;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid   = r_m_valid;
    assign o_m_axis_tdata    = r_m_data;
    assign o_m_axis_tuser[0] = r_m_ovf;

`ifndef ASSERT_OFF
    // the delay being written is never the one being read in the same cycle
    a_dly_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (d_we && d_re) |-> (r_widx != d_raddr))
        else $error("delay write and read hit the same entry");

    // delay writes only come out of the tap walk
    a_dly_we_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d_we |-> (r_state == S_TAP || r_state == S_DRAIN))
        else $error("delay write outside the tap walk");

    // a coefficient write-back follows an accepted write item
    a_cw_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CW) |-> $past(s_acc && (s_op == tiir_pkg::OP_WR_NUM ||
                                              s_op == tiir_pkg::OP_WR_DEN)))
        else $error("coefficient write-back without a write item");

    // a new result only appears from the output state
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> ($past(r_state) == S_OUT))
        else $error("result raised outside the output state");

    // the tap counter stays within the filter order
    a_tap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAP) |-> (r_k != '0 && {1'b0, r_k} <= (CAW + 1)'(ORDER)))
        else $error("tap counter out of range");
`endif

endmodule

`default_nettype wire
